// ----- src/guarded_bitmap_page_allocator_unit_defines.svh -----
// Assertion macros shared by the allocator RTL.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef GUARDED_BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define GUARDED_BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GBPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GBPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBPA_ASSERT_IMP(lbl, ante, cons, msg)
`define GBPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/gbpa_pkg.sv -----
package gbpa_pkg;

	// map word held by one cell of the ring
	localparam int CELL_W     = 16;
	localparam int CELL_IDX_W = 4;

	// payload widths
	localparam int REQ_W   = 23;
	localparam int ROUND_W = 24;
	localparam int ADDR_W  = 48;
	localparam int FIRST_W = 10;

	// byte sizes round up to a multiple of sixteen
	localparam logic [ROUND_W-1:0] ALIGN_MASK = ROUND_W'(15);

	typedef logic [CELL_W-1:0] cell_word_t;

	// outcome of examining one map word
	typedef struct packed {
		logic                  hit;
		logic [CELL_IDX_W-1:0] pos;
	} scan_res_t;

endpackage

// ----- src/gbpa_cell.sv -----
module gbpa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  gbpa_pkg::cell_word_t d,
	output gbpa_pkg::cell_word_t q
);
	import gbpa_pkg::*;

	cell_word_t word_q;

	// every page starts free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ----- src/gbpa_scan.sv -----
module gbpa_scan #(
	parameter int PAGE_ORDER = 12,
	parameter int PAGE_COUNT = 1024
) (
	input  gbpa_pkg::cell_word_t word_in,
	input  logic [((PAGE_COUNT + gbpa_pkg::CELL_W - 1) / gbpa_pkg::CELL_W > 1 ?
		$clog2((PAGE_COUNT + gbpa_pkg::CELL_W - 1) / gbpa_pkg::CELL_W) : 1)-1:0] widx,
	input  logic [gbpa_pkg::ROUND_W-PAGE_ORDER-1:0] carry,
	input  logic [gbpa_pkg::ROUND_W-PAGE_ORDER-1:0] need,
	input  logic                                    mark_en,
	input  logic [((PAGE_COUNT + gbpa_pkg::CELL_W - 1) / gbpa_pkg::CELL_W > 1 ?
		$clog2((PAGE_COUNT + gbpa_pkg::CELL_W - 1) / gbpa_pkg::CELL_W) : 1)
		+ gbpa_pkg::CELL_IDX_W-1:0] first,
	input  logic [((PAGE_COUNT + gbpa_pkg::CELL_W - 1) / gbpa_pkg::CELL_W > 1 ?
		$clog2((PAGE_COUNT + gbpa_pkg::CELL_W - 1) / gbpa_pkg::CELL_W) : 1)
		+ gbpa_pkg::CELL_IDX_W-1:0] last,
	output gbpa_pkg::cell_word_t                    word_out,
	output logic [gbpa_pkg::ROUND_W-PAGE_ORDER-1:0] carry_next,
	output gbpa_pkg::scan_res_t                     res
);
	import gbpa_pkg::*;

	localparam int NCELL  = (PAGE_COUNT + CELL_W - 1) / CELL_W;
	localparam int WIDX_W = NCELL > 1 ? $clog2(NCELL) : 1;
	localparam int IDX_W  = WIDX_W + CELL_IDX_W;
	localparam int NEED_W = ROUND_W - PAGE_ORDER;
	localparam int LAST_N = PAGE_COUNT - (NCELL - 1) * CELL_W;
	localparam logic [CELL_W:0] LAST_ONES = (CELL_W+1)'((2 ** LAST_N) - 1);
	localparam cell_word_t PAD_MASK = ~LAST_ONES[CELL_W-1:0];

	cell_word_t              used;
	logic [CELL_IDX_W:0]     lastu;
	logic [NEED_W:0]         tot [CELL_W];
	logic [CELL_W-1:0]       hit;
	logic [WIDX_W-1:0]       fw;
	logic [WIDX_W-1:0]       lw;
	cell_word_t              lo_mask;
	cell_word_t              hi_mask;
	cell_word_t              mark_mask;

	// pages past the end of the map count as used
	assign used = word_in | ((widx == WIDX_W'(NCELL - 1)) ? PAD_MASK : '0);

	// free-run length ending at each bit, carried in from lower words
	always_comb begin
		lastu = '0;
		for (int j = 0; j < CELL_W; j++) begin
			lastu = '0;
			for (int k = 0; k < CELL_W; k++) begin
				if (k <= j && used[k]) begin
					lastu = (CELL_IDX_W+1)'(k + 1);
				end
			end
			if (lastu == '0) begin
				tot[j] = (NEED_W+1)'(carry) + (NEED_W+1)'(j + 1);
			end else begin
				tot[j] = (NEED_W+1)'(j + 1) - (NEED_W+1)'(lastu);
			end
			hit[j] = tot[j] >= {1'b0, need};
		end
	end

	// lowest bit at which the run reaches the requested length
	always_comb begin
		res.hit = |hit;
		res.pos = '0;
		for (int j = CELL_W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				res.pos = CELL_IDX_W'(j);
			end
		end
	end

	assign carry_next = tot[CELL_W-1][NEED_W-1:0];

	// set the granted run, guard page included
	assign fw      = first[IDX_W-1:CELL_IDX_W];
	assign lw      = last[IDX_W-1:CELL_IDX_W];
	assign lo_mask = (widx == fw) ? ({CELL_W{1'b1}} << first[CELL_IDX_W-1:0])
		: {CELL_W{1'b1}};
	assign hi_mask = (widx == lw) ? ({CELL_W{1'b1}} >> (~last[CELL_IDX_W-1:0]))
		: {CELL_W{1'b1}};
	assign mark_mask = (mark_en && widx >= fw && widx <= lw) ? (lo_mask & hi_mask) : '0;
	assign word_out  = word_in | mark_mask;

endmodule

// ----- src/guarded_bitmap_page_allocator_unit.sv -----
// Channel   Handshake                 Payload
// cfg       cfg_valid / cfg_ready     heap_base
// in        in_valid / in_stall       request_bytes
// out       out_valid / out_stall     granted, block_address, first_page
//
// The page map lives in a ring of ceil(PAGE_COUNT/16) cells that, while a
// search or marking lap runs, moves one 16-bit word a cycle through a single
// scan cell. A request takes one lap to search and, when granted, a second
// lap to mark the run.
// Reset clears the whole map at once in the cells' flops; no clearing pass.
// A result waits in the output register while the next request is taken.
// cfg_ready is always high; write heap_base only while the block is idle.
`include "guarded_bitmap_page_allocator_unit_defines.svh"

module guarded_bitmap_page_allocator_unit #(
	parameter int PAGE_ORDER = 12,
	parameter int PAGE_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gbpa_pkg::ADDR_W-1:0]   heap_base,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gbpa_pkg::REQ_W-1:0]    request_bytes,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic [gbpa_pkg::ADDR_W-1:0]   block_address,
	output logic [gbpa_pkg::FIRST_W-1:0]  first_page
);
	import gbpa_pkg::*;

	localparam int NCELL  = (PAGE_COUNT + CELL_W - 1) / CELL_W;
	localparam int WIDX_W = NCELL > 1 ? $clog2(NCELL) : 1;
	localparam int IDX_W  = WIDX_W + CELL_IDX_W;
	localparam int NEED_W = ROUND_W - PAGE_ORDER;
	localparam int DIFF_W = (IDX_W > NEED_W) ? IDX_W : NEED_W;
	localparam logic [ROUND_W-1:0] PAGE_MASK = ROUND_W'((2 ** PAGE_ORDER) - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_MARK = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [WIDX_W-1:0]   widx_q;
	logic [NEED_W-1:0]   carry_q;
	logic [NEED_W-1:0]   need_q;
	logic [NEED_W-1:0]   pages_q;
	logic [ROUND_W-1:0]  rounded_q;
	logic                found_q;
	logic [IDX_W-1:0]    last_q;
	logic [IDX_W-1:0]    first_q;
	logic [ADDR_W-1:0]   off_q;
	logic [ADDR_W-1:0]   heap_base_q;

	logic                out_valid_q;
	logic                granted_q;
	logic [ADDR_W-1:0]   block_address_q;
	logic [FIRST_W-1:0]  first_page_q;

	logic [ROUND_W-1:0]  bytes_ext;
	logic [ROUND_W-1:0]  rounded;
	logic [ROUND_W-1:0]  page_sum;
	logic [NEED_W-1:0]   pages;

	logic                rotate;
	logic                mark_en;
	logic                lap_end;
	logic                out_free;
	cell_word_t          ring_d [NCELL];
	cell_word_t          ring_q [NCELL];
	cell_word_t          scan_word;
	logic [NEED_W-1:0]   carry_next;
	scan_res_t           scan_res;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);

	// size rounding and page count; the page size is a multiple of sixteen,
	// so the pages follow from the raw byte count
	assign bytes_ext = {1'b0, request_bytes};
	assign rounded   = (bytes_ext + ALIGN_MASK) & ~ALIGN_MASK;
	assign page_sum  = bytes_ext + PAGE_MASK;
	assign pages     = page_sum[ROUND_W-1:PAGE_ORDER];

	assign rotate   = (state_q == ST_SCAN) || (state_q == ST_MARK);
	assign mark_en  = (state_q == ST_MARK);
	assign lap_end  = (widx_q == WIDX_W'(NCELL - 1));
	assign out_free = !out_valid_q || !out_stall;

	// ring of map words: the tail feeds the scan cell, whose output re-enters
	// at the head; after one lap every word is back in place
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign ring_d[k] = scan_word;
		end else begin : g_body
			assign ring_d[k] = ring_q[k-1];
		end
		gbpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (rotate),
			.d      (ring_d[k]),
			.q      (ring_q[k])
		);
	end

	gbpa_scan #(
		.PAGE_ORDER (PAGE_ORDER),
		.PAGE_COUNT (PAGE_COUNT)
	) u_scan (
		.word_in    (ring_q[NCELL-1]),
		.widx       (widx_q),
		.carry      (carry_q),
		.need       (need_q),
		.mark_en    (mark_en),
		.first      (first_q),
		.last       (last_q),
		.word_out   (scan_word),
		.carry_next (carry_next),
		.res        (scan_res)
	);

	// heap base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			heap_base_q <= heap_base;
		end
	end

	// sequencer: accept, search lap, then (when a run is found) prepare and marking lap, hand over result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			widx_q  <= '0;
			found_q <= 1'b0;
			carry_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						widx_q  <= '0;
						found_q <= 1'b0;
						carry_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					carry_q <= carry_next;
					// hold the first fit, drop later hits
					if (!found_q && scan_res.hit) begin
						found_q <= 1'b1;
					end
					if (lap_end) begin
						widx_q  <= '0;
						state_q <= (found_q || scan_res.hit) ? ST_PREP : ST_DONE;
					end else begin
						widx_q <= widx_q + WIDX_W'(1);
					end
				end
				ST_PREP: begin
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					if (lap_end) begin
						widx_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						widx_q <= widx_q + WIDX_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and run bounds
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rounded_q <= rounded;
			pages_q   <= pages;
			need_q    <= pages + NEED_W'(1);
		end
		if (state_q == ST_SCAN && !found_q && scan_res.hit) begin
			last_q <= {widx_q, scan_res.pos};
		end
		if (state_q == ST_PREP) begin
			first_q <= IDX_W'(DIFF_W'(last_q) - DIFF_W'(pages_q));
			off_q   <= ADDR_W'({last_q, {PAGE_ORDER{1'b0}}}) - ADDR_W'(rounded_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			granted_q       <= found_q;
			block_address_q <= found_q ? (heap_base_q + off_q) : '0;
			first_page_q    <= found_q ? FIRST_W'(first_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted       = granted_q;
	assign block_address = block_address_q;
	assign first_page    = first_page_q;

	`GBPA_ASSERT_IMP(a_prep_aligned, state_q == ST_PREP, (widx_q == '0) && found_q, "marking lap starts off alignment")
	`GBPA_ASSERT_IMP(a_run_in_map, state_q == ST_PREP, int'(last_q) < PAGE_COUNT, "run ends past the page map")
	`GBPA_ASSERT_IMP(a_mark_order, state_q == ST_MARK, first_q <= last_q, "run start beyond run end")
	`GBPA_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q) == ST_DONE, "result loaded outside completion")

endmodule

// ----- test/tb_guarded_bitmap_page_allocator_unit.sv -----
`timescale 1ns / 100ps

module tb_guarded_bitmap_page_allocator_unit;
	import gbpa_pkg::*;

	// Geometry of the block under test: 4 KiB pages, 1024 of them
	localparam int PAGE_ORDER = 12;
	localparam int PAGE_COUNT = 1024;
	localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_ORDER;
	localparam longint unsigned SIZE_GRAIN = 64'd15;
	localparam logic [REQ_W-1:0] REQ_MAX = '1;
	// Settling wait after the final drain, sized above the slowest request
	localparam int DRAIN_CYCLES = 2 * ((PAGE_COUNT + 15) / 16) + 16;
	localparam int IDLE_PCT = 13;
	localparam int PHASE_REQUESTS = 150;

	// One result: what the allocator grants for a request
	typedef struct packed {
		logic               granted;
		logic [ADDR_W-1:0]  block_address;
		logic [FIRST_W-1:0] first_page;
	} grant_t;

	// One row of the directed table; want is only used when typed is set
	typedef struct packed {
		logic [REQ_W-1:0] bytes;
		logic             typed;
		grant_t           want;
	} dir_row_t;

	localparam grant_t REFUSED = '{1'b0, '0, '0};

	// Directed requests, map empty and heap base at its reset value of zero
	localparam int DIR_ROWS = 16;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// zero size: only the guard page, at page 0, address 0
		'{23'd0,       1'b1, '{1'b1, 48'd0, 10'd0}},
		// every request bit set: far beyond the map, refused
		'{REQ_MAX,     1'b1, REFUSED},
		// largest legal size: 1024 pages plus guard, cannot fit
		'{23'd4194304, 1'b1, REFUSED},
		// 1023 pages plus guard would fill an empty map, but page 0 is gone
		'{23'd4190208, 1'b1, REFUSED},
		'{23'd1,       1'b0, REFUSED},
		'{23'd15,      1'b0, REFUSED},
		'{23'd16,      1'b0, REFUSED},
		'{23'd17,      1'b0, REFUSED},
		'{23'd4080,    1'b0, REFUSED},
		'{23'd4081,    1'b0, REFUSED},
		'{23'd4095,    1'b0, REFUSED},
		'{23'd4096,    1'b0, REFUSED},
		'{23'd4097,    1'b0, REFUSED},
		'{23'd8192,    1'b0, REFUSED},
		'{23'd0,       1'b0, REFUSED},
		'{23'd65535,   1'b0, REFUSED}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] heap_base = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [REQ_W-1:0]  request_bytes = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              granted;
	logic [ADDR_W-1:0] block_address;
	logic [FIRST_W-1:0] first_page;

	// Shadow of the block: page map, heap base, and what is still owed
	bit                page_taken [PAGE_COUNT];
	logic [ADDR_W-1:0] base_shadow = '0;
	grant_t            pending_grants [$];
	grant_t            oldest_grant;
	bit                idle_on = 1'b1;

	int pages_taken = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int grants_seen = 0;
	int refusals_seen = 0;
	int bases_used = 0;

	guarded_bitmap_page_allocator_unit #(
		.PAGE_ORDER (PAGE_ORDER),
		.PAGE_COUNT (PAGE_COUNT)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.heap_base     (heap_base),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.request_bytes (request_bytes),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.granted       (granted),
		.block_address (block_address),
		.first_page    (first_page)
	);

	always #5 clk = ~clk;

	// First fit over the shadow map; marks the run (guard included) on success
	function automatic grant_t allocate_pages(input logic [REQ_W-1:0] bytes);
		grant_t          res;
		longint unsigned rounded;
		longint unsigned need;
		longint unsigned run;
		longint unsigned first;
		bit              found;
		int              i;
		rounded = (64'(bytes) + SIZE_GRAIN) & ~SIZE_GRAIN;
		need = ((rounded + PAGE_BYTES - 1) >> PAGE_ORDER) + 1;
		run = 0;
		first = 0;
		found = 1'b0;
		res = REFUSED;
		for (i = 0; i < PAGE_COUNT && !found; i++) begin
			if (page_taken[i]) begin
				run = 0;
			end else begin
				run++;
				if (run == need) begin
					first = longint'(i) + 1 - need;
					found = 1'b1;
				end
			end
		end
		if (found) begin
			for (i = 0; i < int'(need); i++)
				page_taken[int'(first) + i] = 1'b1;
			pages_taken += int'(need);
			res.granted = 1'b1;
			res.block_address = ADDR_W'(64'(base_shadow) + (first + need - 1) * PAGE_BYTES
				- rounded);
			res.first_page = FIRST_W'(first);
		end
		return res;
	endfunction

	function automatic int pages_free();
		return PAGE_COUNT - pages_taken;
	endfunction

	// Offer one request; hold it until taken, then log what it should give
	task automatic push_request(input logic [REQ_W-1:0] bytes, input bit typed,
			input grant_t want);
		grant_t predicted;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		request_bytes <= bytes;
		do @(posedge clk); while (in_stall);
		// advance the shadow map even when the row carries its own answer
		predicted = allocate_pages(bytes);
		pending_grants.push_back(typed ? want : predicted);
		requests_sent++;
		if (predicted.granted)
			grants_seen++;
		else
			refusals_seen++;
	endtask

	// Drop valid and let every owed result come home
	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_grants.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	// Move the heap base; only called with the block idle
	task automatic write_heap_base(input logic [ADDR_W-1:0] base);
		drain_requests();
		cfg_valid <= 1'b1;
		heap_base <= base;
		do @(posedge clk); while (!cfg_ready);
		base_shadow = base;
		bases_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random request size; mostly small runs, some sized round the free space
	function automatic logic [REQ_W-1:0] pick_size();
		int pick;
		int room;
		pick = $urandom_range(99);
		room = pages_free();
		if (pick < 15)
			return '0;
		if (pick < 55)
			return REQ_W'($urandom_range(1, 4096));
		if (pick < 65)
			return REQ_W'($urandom_range(4097, 16384));
		// one to sixteen bytes too many for the whole free tail
		if (pick < 75)
			return (room == 0) ? REQ_W'(1) : REQ_W'((room - 1) * 4096 + $urandom_range(1, 16));
		if (pick < 95)
			return REQ_W'($urandom_range((room + 1) * 4096, 4194304));
		return REQ_W'($urandom_range(0, 8388607));
	endfunction

	// Return side: stall at random, independent of the request side
	always @(negedge clk)
		out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

	task automatic note_mismatch(input string field, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
	endtask

	// Compare each taken result with the oldest outstanding request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request outstanding", $realtime);
			end else begin
				oldest_grant = pending_grants.pop_front();
				if (granted !== oldest_grant.granted)
					note_mismatch("granted", ADDR_W'(oldest_grant.granted), ADDR_W'(granted));
				if (block_address !== oldest_grant.block_address)
					note_mismatch("block_address", oldest_grant.block_address, block_address);
				if (first_page !== oldest_grant.first_page)
					note_mismatch("first_page", ADDR_W'(oldest_grant.first_page),
						ADDR_W'(first_page));
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [ADDR_W-1:0] phase_base [5];
		int p;
		int n;
		phase_base[0] = '1;
		phase_base[1] = 48'hFFFF_FFFF_F000;
		phase_base[2] = ADDR_W'({$urandom, $urandom});
		phase_base[3] = '0;
		phase_base[4] = 48'h7FFF_8000_0010;

		// hold reset, then release it away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table against the reset value of the heap base
		for (n = 0; n < DIR_ROWS; n++)
			push_request(DIRECTED[n].bytes, DIRECTED[n].typed, DIRECTED[n].want);

		// random phases, each under its own heap base; the second runs flat out
		for (p = 0; p < 5; p++) begin
			write_heap_base(phase_base[p]);
			idle_on = (p != 1);
			for (n = 0; n < PHASE_REQUESTS; n++)
				push_request(pick_size(), 1'b0, REFUSED);
		end
		idle_on = 1'b1;

		// close out the map: overshoot, exact fit of the free tail, then refusals
		write_heap_base(ADDR_W'({$urandom, $urandom}));
		if (pages_free() > 0)
			push_request(REQ_W'((pages_free() - 1) * 4096 + 1), 1'b0, REFUSED);
		if (pages_free() > 0)
			push_request(REQ_W'((pages_free() - 1) * 4096), 1'b0, REFUSED);
		push_request('0, 1'b0, REFUSED);
		push_request(23'd4194304, 1'b0, REFUSED);
		push_request(REQ_W'(1), 1'b0, REFUSED);

		drain_requests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += pending_grants.size();

		$display("Ran %0d allocation requests over %0d heap bases: %0d granted, %0d refused.",
			requests_sent, bases_used + 1, grants_seen, refusals_seen);
		$display("Page map ended with %0d of %0d pages in use; %0d mismatches.",
			pages_taken, PAGE_COUNT, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
